// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is low
`define AST_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off while reset is low
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/szrt_pkg.sv =====
package szrt_pkg;

    localparam int ADDR_BITS = 48;
    localparam int LEN_BITS  = 32;
    localparam int ZONE_BITS = 5;
    localparam int GRAN_BITS = 16;

    localparam logic [LEN_BITS-1:0] LEN_LIMIT = 32'hFFFF_FFFF;

    localparam logic [1:0] MODE_DISABLE = 2'd0;
    localparam logic [1:0] MODE_ENABLE  = 2'd1;
    localparam logic [1:0] MODE_QUERY   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_ADDR  = 2'd1;
    localparam logic [1:0] ST_BAD_ZONE  = 2'd2;

    typedef struct packed {
        logic [1:0]           mode;
        logic [ZONE_BITS-1:0] zone;
        logic [ADDR_BITS-1:0] range_lo;
        logic [ADDR_BITS-1:0] range_hi;
    } t_req;

    typedef struct packed {
        logic [1:0]          status;
        logic                query_hit;
        logic                issue;
        logic [LEN_BITS-1:0] addr_code;
        logic [LEN_BITS-1:0] region_size;
        logic [LEN_BITS-1:0] zone_word;
    } t_res;

    typedef struct packed {
        logic load_req;
        logic eval;
        logic walk_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic walk_need;
        logic walk_last;
    } t_sts;

endpackage

// ===== rtl/szrt_ram.sv =====
module szrt_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/szrt_ctrl.sv =====
module szrt_ctrl import szrt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic busy,
    output logic o_strobe
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_WALK,
        S_DRAIN,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_strobe;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_sts.walk_need ? S_WALK : S_FIN;
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == S_FIN);
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;

endmodule

// ===== rtl/szrt_dp.sv =====
module szrt_dp import szrt_pkg::*; #(
    parameter int ZONE_COUNT = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_req                 i_req,
    input  logic                 i_cfg_we,
    input  logic [ZONE_BITS-1:0] i_cfg_wdata,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    output t_res                 o_res
);

    localparam int ZW    = $clog2(ZONE_COUNT);
    localparam int ENT_W = ADDR_BITS + LEN_BITS;

    logic [ZONE_BITS-1:0]  r_lowest;
    logic [ZONE_COUNT-1:0] r_active;
    t_req                  r_req;
    t_res                  r_res;
    logic                  r_rng_ok;
    logic                  r_zn_ok;
    logic                  r_pre_ok;
    logic                  r_hit;
    logic [LEN_BITS-1:0]   r_len;
    logic                  r_ovl;
    logic [ZW-1:0]         r_idx;
    logic [ZW-1:0]         r_chk_idx;
    logic                  r_chk_vld;

    logic [ZW-1:0]         zidx;
    logic [ZW-1:0]         raddr;
    logic [ENT_W-1:0]      rdata;
    logic [ENT_W-1:0]      wdata;
    logic                  ram_we;
    logic [ADDR_BITS-1:0]  s_addr;
    logic [ADDR_BITS-1:0]  e_addr;
    logic [ADDR_BITS-1:0]  diff;
    logic [ADDR_BITS-1:0]  e_minus_b;
    logic [ADDR_BITS-1:0]  ent_base;
    logic [LEN_BITS-1:0]   ent_len;
    logic [LEN_BITS-1:0]   len;
    logic [ADDR_BITS:0]    ent_end;
    logic                  rng_ok;
    logic                  zn_ok;
    logic                  act;
    logic                  dis_ok;
    logic                  en_ok;
    logic                  hit;
    logic                  ovl_ent;
    logic                  is_en;
    logic                  cmd_ok;
    t_res                  res;

    assign zidx     = r_req.zone[ZW-1:0];
    assign raddr    = i_cmd.load_req ? i_req.zone[ZW-1:0] : r_idx;
    assign s_addr   = r_req.range_lo;
    assign e_addr   = r_req.range_hi;
    assign ent_base = rdata[ENT_W-1:LEN_BITS];
    assign ent_len  = rdata[LEN_BITS-1:0];

    assign diff   = e_addr - s_addr;
    assign len    = diff[LEN_BITS-1:0];
    assign rng_ok = (s_addr < e_addr) && (diff < ADDR_BITS'(LEN_LIMIT));
    assign zn_ok  = ({1'b0, r_req.zone} < (ZONE_BITS + 1)'(ZONE_COUNT))
                    && (r_req.zone >= r_lowest);
    assign act    = zn_ok && r_active[zidx];
    assign dis_ok = act && (ent_base == s_addr) && (ent_len == len);
    assign en_ok  = (s_addr != '0) && (s_addr[GRAN_BITS-1:0] == '0)
                    && (len[LEN_BITS-1:GRAN_BITS] != '0)
                    && (len[GRAN_BITS-1:0] == '0) && !act;
    assign e_minus_b = e_addr - ent_base;
    assign hit    = act && rng_ok && (s_addr >= ent_base)
                    && (e_minus_b <= ADDR_BITS'(ent_len));

    assign o_sts.walk_need = (r_req.mode == MODE_ENABLE) && rng_ok && zn_ok && en_ok;
    assign o_sts.walk_last = (r_idx == ZW'(ZONE_COUNT - 1));

    // [s,e) against [b, b+len) of one active entry
    assign ent_end = {1'b0, ent_base} + (ADDR_BITS + 1)'(ent_len);
    assign ovl_ent = r_active[r_chk_idx] &&
                     ((s_addr < ent_base) ? (ent_base < e_addr)
                                          : ({1'b0, s_addr} < ent_end));

    assign is_en  = (r_req.mode == MODE_ENABLE);
    assign cmd_ok = r_rng_ok && r_zn_ok && r_pre_ok && (!is_en || !r_ovl);

    always_comb begin
        res = '0;
        case (r_req.mode)
            MODE_QUERY: begin
                res.query_hit = r_hit;
            end
            MODE_DISABLE, MODE_ENABLE: begin
                if (!r_rng_ok) begin
                    res.status = ST_BAD_ADDR;
                end else if (!r_zn_ok) begin
                    res.status = ST_BAD_ZONE;
                end else if (!cmd_ok) begin
                    res.status = ST_BAD_ADDR;
                end else begin
                    res.issue       = 1'b1;
                    res.addr_code   = s_addr[ADDR_BITS-1:GRAN_BITS];
                    res.region_size = r_len;
                    res.zone_word   = {16'(r_req.zone), 15'd0, is_en};
                end
            end
            default: begin
                res = '0;
            end
        endcase
    end

    assign ram_we = i_cmd.finish && res.issue && is_en;
    assign wdata  = {s_addr, r_len};

    szrt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (ZONE_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (zidx),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowest  <= '0;
            r_active  <= '0;
            r_chk_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_lowest <= i_cfg_wdata;
            end
            if (i_cmd.finish && res.issue) begin
                r_active[zidx] <= is_en;
            end
            r_chk_vld <= i_cmd.walk_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req;
        end
        if (i_cmd.eval) begin
            r_rng_ok <= rng_ok;
            r_zn_ok  <= zn_ok;
            r_pre_ok <= (r_req.mode == MODE_DISABLE) ? dis_ok : en_ok;
            r_hit    <= hit;
            r_len    <= len;
            r_ovl    <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (i_cmd.walk_step) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_chk_vld) begin
                r_ovl <= r_ovl | ovl_ent;
            end
        end
        r_chk_idx <= r_idx;
        if (i_cmd.finish) begin
            r_res <= res;
        end
    end

    assign o_res = r_res;

endmodule

// ===== rtl/secure_zone_region_table_unit.sv =====
// channel   | signals                      | beat taken when
// ----------+------------------------------+-------------------------
// request   | start, busy, i_req           | start && !busy
// result    | o_strobe, o_res              | o_strobe (one cycle)
// config    | i_cfg_we, i_cfg_wdata        | i_cfg_we
//
// Disable, query, rejected and unused-mode beats pass through EVAL and FIN;
// no new beat is taken until the last one's result is shown.
// Enable that passes its checks goes EVAL, WALK, DRAIN, FIN and in WALK
// reads the table RAM one entry a cycle, limited by its single read port.
// Synchronous active-low reset clears the active bits and lowest_zone.
// The result cannot be stalled; busy drops as the result is shown.
module secure_zone_region_table_unit import szrt_pkg::*; #(
    parameter int ZONE_COUNT = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  t_req                 i_req,
    output logic                 busy,
    input  logic                 i_cfg_we,
    input  logic [ZONE_BITS-1:0] i_cfg_wdata,
    output logic                 o_strobe,
    output t_res                 o_res
);

    t_cmd cmd;
    t_sts sts;

    szrt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_strobe (o_strobe)
    );

    szrt_dp #(
        .ZONE_COUNT (ZONE_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_res       (o_res)
    );

endmodule

// ===== rtl/szrt_checker.sv =====
`include "assert_macros.svh"

module szrt_checker import szrt_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe,
    input t_res o_res
);

    logic res_clear;
    logic hit_clean;

    assign res_clear = (o_res.addr_code == '0) && (o_res.region_size == '0)
                       && (o_res.zone_word == '0);
    assign hit_clean = (o_res.status == ST_OK) && !o_res.issue;

    `AST_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `AST_IMPL(a_strobe_after_work, i_clk, i_rst_n, o_strobe, $past(busy))
    `AST_IMPL(a_issue_ok, i_clk, i_rst_n, o_strobe && o_res.issue, o_res.status == ST_OK)
    `AST_IMPL(a_no_issue_zero, i_clk, i_rst_n, o_strobe && !o_res.issue, res_clear)
    `AST_IMPL(a_hit_ok, i_clk, i_rst_n, o_strobe && o_res.query_hit, hit_clean)

endmodule

bind secure_zone_region_table_unit szrt_checker u_chk (.*);

// ===== test/secure_zone_region_table_unit_test.sv =====
module secure_zone_region_table_unit_test;
    import szrt_pkg::*;

    localparam int ZONES = 8;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_BEATS = 150;
    localparam int PHASES = 6;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [47:0] GRANULE = 48'h1_0000;
    localparam logic [47:0] LEN_CEILING = 48'hFFFF_FFFF;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic i_cfg_we;
    logic [ZONE_BITS-1:0] i_cfg_wdata;
    logic o_strobe;
    t_req i_req;
    t_res o_res;
    int cycle_count;

    secure_zone_region_table_unit #(.ZONE_COUNT(ZONES)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .i_req(i_req),
        .busy(busy),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_strobe(o_strobe),
        .o_res(o_res)
    );

    class zone_scoreboard;
        logic [ZONE_BITS-1:0] lowest;
        logic [ADDR_BITS-1:0] base [ZONES];
        logic [LEN_BITS-1:0] zone_len [ZONES];
        bit zone_on [ZONES];
        t_res pending_q [$];
        int errors;

        function new();
            lowest = '0;
            errors = 0;
            foreach (base[i]) begin
                base[i] = '0;
                zone_len[i] = '0;
                zone_on[i] = 1'b0;
            end
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            if (errors <= 40) begin
                $display("mismatch %s: got %h want %h", what, got, want);
            end
        endtask

        function bit overlaps(logic [ADDR_BITS-1:0] s, logic [LEN_BITS-1:0] len);
            for (int i = 0; i < ZONES; i++) begin
                if (zone_on[i]) begin
                    if (s < base[i]) begin
                        if ((base[i] - s) < ADDR_BITS'(len)) return 1'b1;
                    end else begin
                        if ((s - base[i]) < ADDR_BITS'(zone_len[i])) return 1'b1;
                    end
                end
            end
            return 1'b0;
        endfunction

        function void note(t_req r);
            t_res x;
            logic [ADDR_BITS-1:0] s;
            logic [ADDR_BITS-1:0] e;
            logic [LEN_BITS-1:0] len;
            bit range_good;
            bit zone_good;
            bit ok;
            int z;
            x = '0;
            s = r.range_lo;
            e = r.range_hi;
            z = int'(r.zone);
            len = LEN_BITS'(e - s);
            range_good = (s < e) && ((e - s) < LEN_CEILING);
            zone_good = (z < ZONES) && (r.zone >= lowest);
            case (r.mode)
                MODE_QUERY: begin
                    if (zone_good && range_good && zone_on[z] && s >= base[z] &&
                        (e - base[z]) <= {16'h0, zone_len[z]}) begin
                        x.query_hit = 1'b1;
                    end
                end
                MODE_DISABLE, MODE_ENABLE: begin
                    if (!range_good) begin
                        x.status = ST_BAD_ADDR;
                    end else if (!zone_good) begin
                        x.status = ST_BAD_ZONE;
                    end else begin
                        if (r.mode == MODE_DISABLE) begin
                            ok = zone_on[z] && base[z] == s && zone_len[z] == len;
                        end else begin
                            ok = s != '0 && s[15:0] == '0 && len != '0 && len[15:0] == '0 &&
                                 !zone_on[z] && !overlaps(s, len);
                        end
                        if (!ok) begin
                            x.status = ST_BAD_ADDR;
                        end else begin
                            x.status = ST_OK;
                            x.issue = 1'b1;
                            x.addr_code = s[47:16];
                            x.region_size = len;
                            x.zone_word = {11'h0, r.zone, 14'h0, r.mode};
                            zone_on[z] = (r.mode == MODE_ENABLE);
                            base[z] = (r.mode == MODE_ENABLE) ? s : '0;
                            zone_len[z] = (r.mode == MODE_ENABLE) ? len : '0;
                        end
                    end
                end
                default: ;
            endcase
            pending_q.push_back(x);
        endfunction

        task check(t_res got);
            t_res want;
            if (pending_q.size() == 0) begin
                report_mismatch("result with nothing pending", 32'(got.status), '0);
                return;
            end
            want = pending_q.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.query_hit !== want.query_hit)
                report_mismatch("query_hit", 32'(got.query_hit), 32'(want.query_hit));
            if (got.issue !== want.issue)
                report_mismatch("issue", 32'(got.issue), 32'(want.issue));
            if (got.addr_code !== want.addr_code)
                report_mismatch("addr_code", got.addr_code, want.addr_code);
            if (got.region_size !== want.region_size)
                report_mismatch("region_size", got.region_size, want.region_size);
            if (got.zone_word !== want.zone_word)
                report_mismatch("zone_word", got.zone_word, want.zone_word);
        endtask
    endclass

    zone_scoreboard sb;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) sb.check(o_res);
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL secure_zone_region_table_unit");
        $finish;
    end

    function automatic t_req mk(logic [1:0] m, logic [4:0] z, logic [47:0] s, logic [47:0] e);
        t_req r;
        r.mode = m;
        r.zone = z;
        r.range_lo = s;
        r.range_hi = e;
        return r;
    endfunction

    function automatic void fresh_range(output logic [47:0] b, output logic [31:0] len);
        logic [31:0] page;
        page = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 48);
        if (page == '0) page = 32'd1;
        b = {page, 16'h0};
        len = {16'($urandom_range(1, ($urandom_range(0, 9) == 0) ? 16'hFFFF : 6)), 16'h0};
    endfunction

    function automatic t_req random_req();
        t_req r;
        int unsigned pick;
        int unsigned z;
        int unsigned off;
        logic [47:0] b;
        logic [31:0] len;
        bit held;
        pick = $urandom_range(0, 99);
        z = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 31) : $urandom_range(0, ZONES - 1);
        r.zone = ZONE_BITS'(z);
        if (pick < 20) begin
            r.mode = 2'($urandom_range(0, 3));
            r.zone = ZONE_BITS'($urandom_range(0, 31));
            r.range_lo = ADDR_BITS'({$urandom, $urandom});
            r.range_hi = $urandom_range(0, 1) ? ADDR_BITS'({$urandom, $urandom})
                                              : r.range_lo + ADDR_BITS'($urandom);
            return r;
        end
        held = (z < ZONES) && sb.zone_on[z];
        fresh_range(b, len);
        if (pick < 55) begin
            r.mode = MODE_ENABLE;
            r.range_lo = b;
            r.range_hi = b + ADDR_BITS'(len);
            if ($urandom_range(0, 9) == 0)
                r.range_lo += ADDR_BITS'($urandom_range(1, 16'hFFFF));
            if ($urandom_range(0, 9) == 0)
                r.range_hi += ADDR_BITS'($urandom_range(1, 16'hFFFF));
        end else if (pick < 75) begin
            r.mode = MODE_DISABLE;
            if (held) begin
                b = sb.base[z];
                len = sb.zone_len[z];
            end
            r.range_lo = b;
            r.range_hi = b + ADDR_BITS'(len);
            if ($urandom_range(0, 6) == 0) r.range_hi += GRANULE;
            if ($urandom_range(0, 9) == 0) r.range_lo -= GRANULE;
        end else begin
            r.mode = MODE_QUERY;
            if (held) begin
                b = sb.base[z];
                len = sb.zone_len[z];
            end
            off = $urandom_range(0, len - 1);
            r.range_lo = b + ADDR_BITS'(off);
            r.range_hi = b + ADDR_BITS'($urandom_range(off + 1, len));
            if ($urandom_range(0, 4) == 0) r.range_hi = b + ADDR_BITS'(len) + 48'd1;
            if ($urandom_range(0, 9) == 0) r.range_lo = b - 48'd1;
        end
        return r;
    endfunction

    task drive_beat(t_req r);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note(r);
    endtask

    task send_beat(t_req r, bit may_idle);
        drive_beat(r);
        if (may_idle && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task drain();
        start <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
    endtask

    task write_cfg(logic [ZONE_BITS-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        sb.lowest = v;
        i_cfg_we <= 1'b0;
    endtask

    task run_directed();
        write_cfg('0);
        send_beat(mk(MODE_ENABLE, 5'd0, 48'h1_0000, 48'h2_0000), 1'b1);
        send_beat(mk(MODE_ENABLE, 5'd1, 48'h1_0000, 48'h3_0000), 1'b1);
        send_beat(mk(MODE_ENABLE, 5'd1, 48'h0, 48'h1_0000), 1'b1);
        send_beat(mk(MODE_ENABLE, 5'd1, 48'h4_8000, 48'h5_8000), 1'b1);
        send_beat(mk(MODE_ENABLE, 5'd1, 48'h4_0000, 48'h4_8000), 1'b1);
        send_beat(mk(MODE_ENABLE, 5'd0, 48'h8_0000, 48'h9_0000), 1'b1);
        send_beat(mk(MODE_ENABLE, 5'd7, 48'hFFFF_0000_0000, 48'hFFFF_FFFF_0000), 1'b1);
        send_beat(mk(MODE_ENABLE, 5'd8, 48'h10_0000, 48'h11_0000), 1'b1);
        send_beat(mk(MODE_ENABLE, 5'd31, 48'h10_0000, 48'h11_0000), 1'b1);
        send_beat(mk(MODE_DISABLE, 5'd3, 48'h5, 48'h5), 1'b1);
        send_beat(mk(MODE_DISABLE, 5'd31, 48'h20, 48'h10), 1'b1);
        send_beat(mk(MODE_ENABLE, 5'd31, 48'h0, 48'hFFFF_FFFF), 1'b1);
        send_beat(mk(MODE_ENABLE, 5'd31, 48'h1, 48'hFFFF_FFFF), 1'b1);
        send_beat(mk(MODE_QUERY, 5'd0, 48'h1_0000, 48'h2_0000), 1'b1);
        send_beat(mk(MODE_QUERY, 5'd0, 48'h1_8000, 48'h2_0001), 1'b1);
        send_beat(mk(MODE_QUERY, 5'd7, 48'hFFFF_8000_0000, 48'hFFFF_FFFF_0000), 1'b1);
        send_beat(mk(MODE_QUERY, 5'd2, 48'h1_0000, 48'h2_0000), 1'b1);
        send_beat(mk(MODE_QUERY, 5'd9, 48'h1_0000, 48'h2_0000), 1'b1);
        send_beat(mk(MODE_QUERY, 5'd0, 48'h2_0000, 48'h1_0000), 1'b1);
        send_beat(mk(MODE_DISABLE, 5'd0, 48'h1_0000, 48'h3_0000), 1'b1);
        send_beat(mk(MODE_DISABLE, 5'd0, 48'h0, 48'h1_0000), 1'b1);
        send_beat(mk(MODE_DISABLE, 5'd2, 48'h1_0000, 48'h2_0000), 1'b1);
        send_beat(mk(MODE_DISABLE, 5'd0, 48'h1_0000, 48'h2_0000), 1'b1);
        send_beat(mk(MODE_UNUSED, 5'd31, '1, '1), 1'b1);
        // directly below zone 7, touching but not overlapping
        send_beat(mk(MODE_ENABLE, 5'd1, 48'hFFFE_FFFF_0000, 48'hFFFF_0000_0000), 1'b1);
        drain();
        write_cfg(5'd31);
        send_beat(mk(MODE_ENABLE, 5'd3, 48'h40_0000, 48'h41_0000), 1'b1);
        send_beat(mk(MODE_QUERY, 5'd7, 48'hFFFF_0000_0000, 48'hFFFF_FFFF_0000), 1'b1);
        send_beat(mk(MODE_ENABLE, 5'd31, 48'h40_0000, 48'h41_0000), 1'b1);
    endtask

    initial begin
        int beats;
        t_req r;
        logic [ZONE_BITS-1:0] lz;
        sb = new();
        start <= 1'b0;
        i_req <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;
        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase)
                0: lz = 5'd2;
                1: lz = 5'($urandom_range(0, 31));
                2: lz = 5'd7;
                3: lz = 5'd0;
                4: lz = 5'd1;
                default: lz = 5'd0;
            endcase
            write_cfg(lz);
            beats = 0;
            while (beats < PHASE_BEATS) begin
                r = random_req();
                send_beat(r, phase < PHASES - 1);
                if (r.mode != MODE_UNUSED) beats++;
            end
        end
        drain();
        repeat (ZONES + 8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("PASS secure_zone_region_table_unit");
        end else begin
            $display("FAIL secure_zone_region_table_unit");
        end
        $finish;
    end
endmodule

// ===== secure_zone_region_table_unit.f =====
+incdir+rtl
rtl/szrt_pkg.sv
rtl/szrt_ram.sv
rtl/szrt_ctrl.sv
rtl/szrt_dp.sv
rtl/secure_zone_region_table_unit.sv
rtl/szrt_checker.sv
test/secure_zone_region_table_unit_test.sv
